[rtl/ccl_pkg.sv]
// ccl_pkg: shared types, codes and the fixed color palette of the text layout engine
// no dependencies; used by every module under rtl
package ccl_pkg;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_CARET = 8'd94;

	localparam int unsigned PALETTE_SIZE = 16;

	// request opcodes and result kinds
	localparam logic OP_BEGIN    = 1'b0;
	localparam logic OP_CHAR     = 1'b1;
	localparam logic KIND_GLYPH  = 1'b0;
	localparam logic KIND_DONE   = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_START_X    = 3'd0,
		REG_LINE_Y     = 3'd1,
		REG_LIMIT_X    = 3'd2,
		REG_BASE_RED   = 3'd3,
		REG_BASE_GREEN = 3'd4,
		REG_BASE_BLUE  = 3'd5
	} reg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 12;

	localparam logic [11:0] START_X_RST = 12'd0;
	localparam logic [11:0] LINE_Y_RST  = 12'd0;
	localparam logic [11:0] LIMIT_X_RST = 12'd4095;
	localparam logic [7:0]  BASE_RST    = 8'd255;

	localparam int unsigned OUT_DEPTH = 4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [11:0] start_x;
		logic [11:0] line_y;
		logic [11:0] limit_x;
		rgb_t        base;
	} cfg_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] char_code;
		logic [7:0] glyph_width;
	} ccl_in_t;

	typedef struct packed {
		logic        kind;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  glyph_code;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        clipped;
		logic        last;
	} ccl_out_t;

	// up to two results produced by one request
	typedef struct packed {
		logic [1:0] count;
		ccl_out_t   first;
		ccl_out_t   second;
	} ccl_pair_t;

	function automatic rgb_t palette(input logic [3:0] idx);
		rgb_t c;
		unique case (idx)
			4'd0:  c = '{8'd255, 8'd170, 8'd0};
			4'd1:  c = '{8'd255, 8'd0,   8'd0};
			4'd2:  c = '{8'd0,   8'd255, 8'd0};
			4'd3:  c = '{8'd255, 8'd255, 8'd0};
			4'd4:  c = '{8'd0,   8'd0,   8'd255};
			4'd5:  c = '{8'd0,   8'd255, 8'd255};
			4'd6:  c = '{8'd255, 8'd0,   8'd255};
			4'd7:  c = '{8'd136, 8'd136, 8'd136};
			4'd8:  c = '{8'd255, 8'd255, 8'd255};
			4'd9:  c = '{8'd0,   8'd0,   8'd0};
			4'd10: c = '{8'd200, 8'd90,  8'd70};
			4'd11: c = '{8'd145, 8'd215, 8'd140};
			4'd12: c = '{8'd225, 8'd205, 8'd45};
			4'd13: c = '{8'd125, 8'd165, 8'd210};
			4'd14: c = '{8'd70,  8'd70,  8'd70};
			4'd15: c = '{8'd200, 8'd200, 8'd200};
			default: c = '{8'd0, 8'd0, 8'd0};
		endcase
		return c;
	endfunction

endpackage

[rtl/color_coded_text_layout_top.sv]
// color_coded_text_layout_top: streaming text layout with caret color codes
// depends on ccl_pkg, ccl_core and ccl_res_fifo
//
//  channel   signals                          dir  payload
//  char      char_valid / char_ready          in   char_req  (ccl_in_t)
//  glyph     glyph_valid / glyph_ready        out  glyph_res (ccl_out_t)
//  config    cfg_we, cfg_idx                  in   cfg_wdata (12 bit)
//
// a request is registered, then laid out by ccl_core once the result queue has room; one request
// per cycle is taken while the result queue has room for two results.
// results come out one per cycle while glyph_ready is high; a literal caret followed by a
// glyph or a done result yields two results.
// reset empties the queue, loads default registers and waits for a begin request.
// output stalls back up through the queue into the input register and char_ready.
module color_coded_text_layout_top #(
	parameter int unsigned OUT_DEPTH = ccl_pkg::OUT_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              char_valid,
	output logic                              char_ready,
	input  ccl_pkg::ccl_in_t                  char_req,
	output logic                              glyph_valid,
	input  logic                              glyph_ready,
	output ccl_pkg::ccl_out_t                 glyph_res,
	input  logic                              cfg_we,
	input  logic [ccl_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ccl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	ccl_pkg::cfg_t      cfg_q;
	ccl_pkg::ccl_in_t   item_s1;
	logic               valid_s1;
	logic               space;
	logic               advance;
	ccl_pkg::ccl_pair_t pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x <= ccl_pkg::START_X_RST;
			cfg_q.line_y  <= ccl_pkg::LINE_Y_RST;
			cfg_q.limit_x <= ccl_pkg::LIMIT_X_RST;
			cfg_q.base    <= '{ccl_pkg::BASE_RST, ccl_pkg::BASE_RST, ccl_pkg::BASE_RST};
		end else if (cfg_we) begin
			unique case (ccl_pkg::reg_idx_t'(cfg_idx))
				ccl_pkg::REG_START_X:    cfg_q.start_x    <= cfg_wdata;
				ccl_pkg::REG_LINE_Y:     cfg_q.line_y     <= cfg_wdata;
				ccl_pkg::REG_LIMIT_X:    cfg_q.limit_x    <= cfg_wdata;
				ccl_pkg::REG_BASE_RED:   cfg_q.base.red   <= cfg_wdata[7:0];
				ccl_pkg::REG_BASE_GREEN: cfg_q.base.green <= cfg_wdata[7:0];
				ccl_pkg::REG_BASE_BLUE:  cfg_q.base.blue  <= cfg_wdata[7:0];
				default:                 cfg_q            <= cfg_q;
			endcase
		end
	end

	assign advance    = valid_s1 && space;
	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_req;
		end
	end

	ccl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (pair)
	);

	ccl_res_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pair),
		.space     (space),
		.res_valid (glyph_valid),
		.res_ready (glyph_ready),
		.res       (glyph_res)
	);

	// a pair always starts with the literal caret glyph and ends on the last flag
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		pair.count == 2'd2 |-> pair.first.kind == ccl_pkg::KIND_GLYPH
			&& pair.first.glyph_code == ccl_pkg::CH_CARET
			&& !pair.first.last && pair.second.last)
		else $error("bad result pair");

	// nothing is pushed unless a request is being laid out
	a_push_gated: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> pair.count == 2'd0)
		else $error("push without request");

	// a request blocked by a full queue stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !space |=> valid_s1 && $stable(item_s1))
		else $error("request lost while queue full");

	// single results are always marked last
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		pair.count == 2'd1 |-> pair.first.last)
		else $error("single result not marked last");

endmodule

[rtl/ccl_core.sv]
// ccl_core: pen and color state plus the per-character layout decision
// depends on ccl_pkg; gives up to two results per request, combinationally
module ccl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ccl_pkg::ccl_in_t  item,
	input  ccl_pkg::cfg_t     cfg,
	output ccl_pkg::ccl_pair_t res
);

	typedef struct packed {
		logic [11:0]   pen_x;
		ccl_pkg::rgb_t pen;
		logic          caret_pending;
		logic [7:0]    caret_width;
		logic          skip_escape;
		logic          string_done;
	} core_state_t;

	core_state_t st_q;
	core_state_t st_nxt;

	logic [7:0]        c;
	logic [7:0]        w;
	logic              is_term;
	logic              is_caret;
	logic              is_digit;
	logic [7:0]        digit_off;
	logic [12:0]       sum_a;
	logic              fit_a;
	logic [11:0]       x_b;
	logic [12:0]       sum_b;
	logic              fit_b;
	ccl_pkg::ccl_out_t char_res;
	logic              char_emit;
	logic              char_set_caret;
	logic              char_done;
	logic              char_move;
	ccl_pkg::ccl_pair_t res_d;

	function automatic ccl_pkg::ccl_out_t mk(input logic kind, input logic [11:0] x,
		input logic [7:0] code, input logic clip, input logic [11:0] y,
		input ccl_pkg::rgb_t col);
		ccl_pkg::ccl_out_t r;
		r.kind       = kind;
		r.pos_x      = x;
		r.pos_y      = y;
		r.glyph_code = code;
		r.red        = col.red;
		r.green      = col.green;
		r.blue       = col.blue;
		r.clipped    = clip;
		r.last       = 1'b0;
		return r;
	endfunction

	assign c         = item.char_code;
	assign w         = item.glyph_width;
	assign is_term   = (c == ccl_pkg::CH_NUL) || (c == ccl_pkg::CH_NL);
	assign is_caret  = (c == ccl_pkg::CH_CARET);
	assign digit_off = c - ccl_pkg::CH_ZERO;
	assign is_digit  = (c >= ccl_pkg::CH_ZERO) && (c <= ccl_pkg::CH_NINE)
		&& ({24'd0, digit_off} < 32'(ccl_pkg::PALETTE_SIZE));

	// literal caret is drawn first, the character then lands after it
	assign sum_a = {1'b0, st_q.pen_x} + {5'd0, st_q.caret_width};
	assign fit_a = sum_a <= {1'b0, cfg.limit_x};
	assign x_b   = (st_q.caret_pending && !st_q.skip_escape) ? sum_a[11:0] : st_q.pen_x;
	assign sum_b = {1'b0, x_b} + {5'd0, w};
	assign fit_b = sum_b <= {1'b0, cfg.limit_x};

	// character handling at x_b; caret check off right after a color code
	always_comb begin
		char_res       = mk(ccl_pkg::KIND_DONE, x_b, 8'd0, 1'b0, cfg.line_y, st_q.pen);
		char_emit      = 1'b0;
		char_set_caret = 1'b0;
		char_done      = 1'b0;
		char_move      = 1'b0;
		if (is_term) begin
			char_emit = 1'b1;
			char_done = 1'b1;
		end else if (is_caret && !st_q.skip_escape) begin
			char_set_caret = 1'b1;
		end else if (fit_b) begin
			char_emit = 1'b1;
			char_move = 1'b1;
			char_res  = mk(ccl_pkg::KIND_GLYPH, x_b, c, 1'b0, cfg.line_y, st_q.pen);
		end else begin
			char_emit = 1'b1;
			char_done = 1'b1;
			char_res  = mk(ccl_pkg::KIND_DONE, x_b, 8'd0, 1'b1, cfg.line_y, st_q.pen);
		end
	end

	always_comb begin
		st_nxt       = st_q;
		res_d        = '0;
		res_d.first  = char_res;
		res_d.second = char_res;
		if (item.opcode == ccl_pkg::OP_BEGIN) begin
			st_nxt.pen_x         = cfg.start_x;
			st_nxt.pen           = cfg.base;
			st_nxt.caret_pending = 1'b0;
			st_nxt.caret_width   = 8'd0;
			st_nxt.skip_escape   = 1'b0;
			st_nxt.string_done   = 1'b0;
		end else if (st_q.string_done) begin
			st_nxt = st_q;
		end else if (st_q.skip_escape || !st_q.caret_pending) begin
			st_nxt.skip_escape = 1'b0;
			res_d.count        = {1'b0, char_emit};
			if (char_set_caret) begin
				st_nxt.caret_pending = 1'b1;
				st_nxt.caret_width   = w;
			end
			if (char_done) begin
				st_nxt.string_done = 1'b1;
			end
			if (char_move) begin
				st_nxt.pen_x = sum_b[11:0];
			end
		end else begin
			st_nxt.caret_pending = 1'b0;
			if (is_digit) begin
				st_nxt.skip_escape = 1'b1;
				if (digit_off[3:0] == 4'd0) begin
					st_nxt.pen = cfg.base;
				end else begin
					st_nxt.pen = ccl_pkg::palette(digit_off[3:0]);
				end
			end else if (!fit_a) begin
				res_d.count        = 2'd1;
				res_d.first        = mk(ccl_pkg::KIND_DONE, st_q.pen_x, 8'd0, 1'b1,
					cfg.line_y, st_q.pen);
				st_nxt.string_done = 1'b1;
			end else begin
				res_d.first  = mk(ccl_pkg::KIND_GLYPH, st_q.pen_x, ccl_pkg::CH_CARET, 1'b0,
					cfg.line_y, st_q.pen);
				res_d.second = char_res;
				res_d.count  = char_emit ? 2'd2 : 2'd1;
				st_nxt.pen_x = sum_a[11:0];
				if (char_set_caret) begin
					st_nxt.caret_pending = 1'b1;
					st_nxt.caret_width   = w;
				end
				if (char_done) begin
					st_nxt.string_done = 1'b1;
				end
				if (char_move) begin
					st_nxt.pen_x = sum_b[11:0];
				end
			end
		end
		// mark the final result of this request
		if (res_d.count == 2'd1) begin
			res_d.first.last = 1'b1;
		end
		if (res_d.count == 2'd2) begin
			res_d.second.last = 1'b1;
		end
		if (!fire) begin
			res_d.count = 2'd0;
		end
	end

	assign res = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.pen_x         <= ccl_pkg::START_X_RST;
			st_q.pen           <= '{ccl_pkg::BASE_RST, ccl_pkg::BASE_RST, ccl_pkg::BASE_RST};
			st_q.caret_pending <= 1'b0;
			st_q.caret_width   <= 8'd0;
			st_q.skip_escape   <= 1'b0;
			st_q.string_done   <= 1'b1;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

endmodule

[rtl/ccl_res_fifo.sv]
// ccl_res_fifo: result queue; takes up to two results a cycle, gives one while
// res_ready is high; depends on ccl_pkg for the result and result-pair types
module ccl_res_fifo #(
	parameter int unsigned DEPTH = ccl_pkg::OUT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ccl_pkg::ccl_pair_t push,
	output logic               space,
	output logic               res_valid,
	input  logic               res_ready,
	output ccl_pkg::ccl_out_t  res
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ccl_pkg::ccl_out_t mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     wr_ptr1;
	logic              pop;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign wr_ptr1   = inc(wr_ptr_q);
	assign res_valid = (count_q != '0);
	assign res       = mem_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;
	// room for a full pair regardless of what leaves this cycle
	assign space     = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if ((push.count != 2'd0) && (wr_ptr_q == AW'(i))) begin
				mem_q[i] <= push.first;
			end else if ((push.count == 2'd2) && (wr_ptr1 == AW'(i))) begin
				mem_q[i] <= push.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (push.count)
				2'd1:    wr_ptr_q <= wr_ptr1;
				2'd2:    wr_ptr_q <= inc(wr_ptr1);
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule
